// File: sv/ofkd_pkg.sv
// shared constants and types for the overwrite fifo with keyed drain
// no dependencies; imported by the store, the top level and the checker
package ofkd_pkg;

    localparam int ID_W                = 32;
    localparam int CAP_W               = 7;
    localparam int DEFAULT_MAX_ENTRIES = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // operation codes carried on s_tuser
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // one stored pair
    typedef struct packed {
        logic [ID_W-1:0] grp;
        logic [ID_W-1:0] obj;
    } entry_t;

endpackage

// File: sv/ofkd_store.sv
// pair storage: one write port, one read port with registered read data
// depends on ofkd_pkg for entry_t
module ofkd_store import ofkd_pkg::*; #(
    parameter int DEPTH = DEFAULT_MAX_ENTRIES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_entry,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_entry
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        rd_entry <= mem[rd_addr];
    end

endmodule

// File: sv/overwrite_fifo_keyed_drain_unit.sv
// overwrite fifo with keyed drain: an add's result is registered and appears the cycle after.
// drain walks held entries newest to oldest, one per cycle over the single store read port,
// stalling while the result register is full on a second match or on the last result.
// one add per cycle unless results stall; a drain blocks requests until its last result loads.
// reset (aresetn low, synchronous) empties the store and sets capacity to 64 at once;
// stored pairs are not cleared and no clearing pass is run.
module overwrite_fifo_keyed_drain_unit import ofkd_pkg::*; #(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,   // capacity
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2*ID_W-1:0] s_tdata,       // [31:0] object_id, [63:32] group_id
    input  logic              s_tuser,       // [0] operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ID_W-1:0]   m_tdata,       // [31:0] object_out
    output logic [1:0]        m_tuser,       // [0] found, [1] evicted
    output logic              m_tlast        // last
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == TOP_ADDR) ? '0 : AW'(p + 1'b1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? TOP_ADDR : AW'(p - 1'b1);
    endfunction

    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [ID_W-1:0]  grp_reg, grp_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    keep_reg, keep_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]  pend_obj_reg, pend_obj_next;
    logic             m_valid_reg, m_valid_next;
    logic [ID_W-1:0]  m_obj_reg, m_obj_next;
    logic             m_found_reg, m_found_next;
    logic             m_evict_reg, m_evict_next;
    logic             m_last_reg, m_last_next;

    logic             out_free, s_acc, in_op, match, stall, evict;
    logic [ID_W-1:0]  in_obj, in_grp;
    logic [CW-1:0]    eff_cap;
    logic             wr_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    entry_t           wr_entry, rd_entry;

    ofkd_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    assign in_obj   = s_tdata[ID_W-1:0];
    assign in_grp   = s_tdata[2*ID_W-1:ID_W];
    assign in_op    = s_tuser;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;

    // capacity saturated into 1..MAX_ENTRIES
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CW'(1);
        end else if (32'(cap_reg) > 32'(MAX_ENTRIES)) begin
            eff_cap = CW'(MAX_ENTRIES);
        end else begin
            eff_cap = CW'(cap_reg);
        end
    end

    assign evict = (count_reg >= eff_cap);
    assign match = (rd_entry.grp == grp_reg);
    // a second match can't move on until the result register can take the held one
    assign stall = match && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        grp_next        = grp_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        pend_valid_next = pend_valid_reg;
        pend_obj_next   = pend_obj_reg;
        m_valid_next    = m_tready ? 1'b0 : m_valid_reg;
        m_obj_next      = m_obj_reg;
        m_found_next    = m_found_reg;
        m_evict_next    = m_evict_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        wr_entry        = '{grp: in_grp, obj: in_obj};
        rd_addr         = rp_reg;

        case (state_reg)
            ST_IDLE: begin
                rd_addr = ptr_dec(tail_reg);
                if (s_acc) begin
                    if (in_op == OP_ADD) begin
                        wr_en     = 1'b1;
                        tail_next = ptr_inc(tail_reg);
                        if (evict) begin
                            head_next = ptr_inc(head_reg);
                        end else begin
                            count_next = CW'(count_reg + 1'b1);
                        end
                        m_valid_next = 1'b1;
                        m_obj_next   = '0;
                        m_found_next = 1'b0;
                        m_evict_next = evict;
                        m_last_next  = 1'b1;
                    end else if (count_reg == '0) begin
                        m_valid_next = 1'b1;
                        m_obj_next   = '0;
                        m_found_next = 1'b0;
                        m_evict_next = 1'b0;
                        m_last_next  = 1'b1;
                    end else begin
                        grp_next        = in_grp;
                        rp_next         = ptr_dec(tail_reg);
                        wp_next         = ptr_dec(tail_reg);
                        idx_next        = count_reg;
                        keep_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_addr = stall ? rp_reg : ptr_dec(rp_reg);
                if (!stall) begin
                    if (match) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_obj_next   = pend_obj_reg;
                            m_found_next = 1'b1;
                            m_evict_next = 1'b0;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_obj_next   = rd_entry.obj;
                    end else begin
                        // compact toward the newest end, order kept
                        wr_en     = 1'b1;
                        wr_addr   = wp_reg;
                        wr_entry  = rd_entry;
                        wp_next   = ptr_dec(wp_reg);
                        keep_next = CW'(keep_reg + 1'b1);
                    end
                    rp_next  = ptr_dec(rp_reg);
                    idx_next = CW'(idx_reg - 1'b1);
                    if (idx_reg == CW'(1)) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_obj_next      = pend_valid_reg ? pend_obj_reg : '0;
                    m_found_next    = pend_valid_reg;
                    m_evict_next    = 1'b0;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    head_next       = ptr_inc(wp_reg);
                    count_next      = keep_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            cap_reg        <= CAP_RESET;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg      <= grp_next;
        rp_reg       <= rp_next;
        wp_reg       <= wp_next;
        idx_reg      <= idx_next;
        keep_reg     <= keep_next;
        pend_obj_reg <= pend_obj_next;
        m_obj_reg    <= m_obj_next;
        m_found_reg  <= m_found_next;
        m_evict_reg  <= m_evict_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_obj_reg;
    assign m_tuser  = {m_evict_reg, m_found_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: sv/ofkd_checker.sv
// port-level checks for the overwrite fifo with keyed drain, bound to the top level
// depends on ofkd_pkg for widths and operation codes
module ofkd_port_checks import ofkd_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [2*ID_W-1:0] s_tdata,
    input logic              s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [ID_W-1:0]   m_tdata,
    input logic [1:0]        m_tuser,
    input logic              m_tlast
);

    // an add always answers in the next cycle with one final, empty result
    a_add_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_ADD)
        |=> m_tvalid && m_tlast && !m_tuser[0] && (m_tdata == '0))
        else $error("add did not produce its result");

    // a result without a drained object carries a zero id
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
        else $error("object id nonzero without found");

    // eviction is only flagged on the single result of an add
    a_evict_only_add: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("evicted flag on a drain result");

    // no new request while a drain still has results to give
    a_no_accept_mid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken during a drain");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind overwrite_fifo_keyed_drain_unit ofkd_port_checks u_ofkd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: sim/ofkd_checker.sv
// checker for the overwrite fifo with keyed drain: watches both stream channels and the
// capacity port, predicts every result and compares it in order
// depends on ofkd_pkg for widths, operation codes and the default store depth
module ofkd_checker import ofkd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [2*ID_W-1:0] s_tdata,      // [31:0] object_id, [63:32] group_id
    input  logic              s_tuser,      // [0] operation
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [ID_W-1:0]   m_tdata,      // [31:0] object_out
    input  logic [1:0]        m_tuser,      // [0] found, [1] evicted
    input  logic              m_tlast,
    output int                expected_left,
    output int                fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEFAULT_MAX_ENTRIES;

    typedef struct packed {
        logic [ID_W-1:0] obj;
        logic            found;
        logic            evicted;
        logic            last;
    } drain_result_t;

    logic [ID_W-1:0]  obj_mem [DEPTH];
    logic [ID_W-1:0]  grp_mem [DEPTH];
    int               held;
    logic [CAP_W-1:0] cap_reg;
    drain_result_t    awaited_results [$];
    int               fails;

    initial begin
        expected_left = 0;
        fail_count    = 0;
        held          = 0;
        fails         = 0;
        cap_reg       = CAP_RESET;
    end

    function automatic int usable_capacity();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > DEPTH)
            return DEPTH;
        return int'(cap_reg);
    endfunction

    function automatic void push_result(logic [ID_W-1:0] obj, logic found, logic evicted,
                                        logic last);
        drain_result_t r;
        r.obj     = obj;
        r.found   = found;
        r.evicted = evicted;
        r.last    = last;
        awaited_results.push_back(r);
    endfunction

    // update the store for one request and queue the results it causes
    function automatic void model_request(logic op, logic [ID_W-1:0] obj,
                                          logic [ID_W-1:0] grp);
        int              keep;
        logic            evc;
        logic [ID_W-1:0] hits [$];
        keep = 0;
        evc  = 1'b0;
        if (op == OP_ADD) begin
            if (held >= usable_capacity() && held > 0) begin
                for (int i = 1; i < held; i++) begin
                    obj_mem[i-1] = obj_mem[i];
                    grp_mem[i-1] = grp_mem[i];
                end
                held--;
                evc = 1'b1;
            end
            obj_mem[held] = obj;
            grp_mem[held] = grp;
            held++;
            push_result('0, 1'b0, evc, 1'b1);
        end else begin
            for (int i = 0; i < held; i++) begin
                if (grp_mem[i] == grp) begin
                    hits.push_back(obj_mem[i]);
                end else begin
                    obj_mem[keep] = obj_mem[i];
                    grp_mem[keep] = grp_mem[i];
                    keep++;
                end
            end
            held = keep;
            if (hits.size() == 0) begin
                push_result('0, 1'b0, 1'b0, 1'b1);
            end else begin
                // newest match comes out first
                for (int k = hits.size() - 1; k >= 0; k--)
                    push_result(hits[k], 1'b1, 1'b0, k == 0);
            end
        end
    endfunction

    function automatic void report_failure(string what);
        if (fails < 10)
            $display("[%0t] mismatch: %s", $realtime, what);
        fails++;
    endfunction

    always @(posedge aclk) begin
        drain_result_t want;
        if (!aresetn) begin
            held    = 0;
            cap_reg = CAP_RESET;
            awaited_results.delete();
        end else begin
            if (cfg_wr_en)
                cap_reg = cfg_wr_data;
            // results first, so a result can never match a request of the same edge
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_failure($sformatf("unexpected result obj=%h found=%b evicted=%b last=%b",
                                             m_tdata, m_tuser[0], m_tuser[1], m_tlast));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata !== want.obj || m_tuser[0] !== want.found ||
                        m_tuser[1] !== want.evicted || m_tlast !== want.last)
                        report_failure($sformatf(
                            "expected obj=%h found=%b evicted=%b last=%b, got obj=%h found=%b evicted=%b last=%b",
                            want.obj, want.found, want.evicted, want.last,
                            m_tdata, m_tuser[0], m_tuser[1], m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                model_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[2*ID_W-1:ID_W]);
        end
        expected_left <= awaited_results.size();
        fail_count    <= fails;
    end

endmodule

// File: sim/tb_overwrite_fifo_keyed_drain_unit.sv
// testbench top for overwrite_fifo_keyed_drain_unit: drives directed and random add/drain
// requests at several capacities, stalls the result side, and gives the verdict
// depends on ofkd_pkg, the unit itself and ofkd_checker
module tb_overwrite_fifo_keyed_drain_unit;
    import ofkd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = DEFAULT_MAX_ENTRIES + 8;
    localparam int NUM_PHASES    = 6;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [2*ID_W-1:0] s_tdata     = '0;
    logic              s_tuser     = OP_ADD;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [ID_W-1:0]   m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    int                expected_left;
    int                fail_count;

    int                burst_left = 0;
    int                ready_mode = 0;
    int                mode_left  = 0;
    logic [ID_W-1:0]   group_pool [6];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    overwrite_fifo_keyed_drain_unit #(.MAX_ENTRIES(DEFAULT_MAX_ENTRIES)) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    ofkd_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .expected_left (expected_left),
        .fail_count    (fail_count)
    );

    // result side: switches between always ready, coin-flip and mostly stalled
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // offers one request and returns at the edge where it is taken; valid stays high
    task automatic send_request(logic op, logic [ID_W-1:0] obj, logic [ID_W-1:0] grp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {grp, obj};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every result is back and the unit has had time to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [ID_W-1:0] pick_group();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return group_pool[$urandom_range(0, 5)];
    endfunction

    initial begin
        logic [ID_W-1:0]  grp_a;
        logic [ID_W-1:0]  grp_b;
        logic [CAP_W-1:0] phase_cap [NUM_PHASES];
        int               phase_len [NUM_PHASES];
        int               add_pct   [NUM_PHASES];

        phase_cap = '{7'd64, 7'd65, 7'd5, 7'd1, 7'd0, 7'd1};
        phase_len = '{56, 30, 40, 25, 15, 30};
        add_pct   = '{88, 65, 70, 60, 55, 70};
        phase_cap[5] = CAP_W'($urandom_range(1, DEFAULT_MAX_ENTRIES));
        grp_a = $urandom;
        grp_b = ~grp_a;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // drain of an empty store, then extremes of both ids
        send_request(OP_DRAIN, '0, '0);
        send_request(OP_ADD, '0, '0);
        send_request(OP_ADD, '1, '1);
        send_request(OP_ADD, 32'h1234_5678, '0);
        send_request(OP_DRAIN, '0, '0);
        send_request(OP_DRAIN, '0, '1);
        send_request(OP_DRAIN, '1, '1);

        // capacity of one: every add after the first evicts
        wait_idle();
        write_capacity(7'd1);
        send_request(OP_ADD, $urandom, grp_a);
        send_request(OP_ADD, $urandom, grp_a);
        send_request(OP_ADD, $urandom, grp_b);
        send_request(OP_DRAIN, '0, grp_b);

        // zero capacity behaves as one
        wait_idle();
        write_capacity(7'd0);
        send_request(OP_ADD, $urandom, grp_a);
        send_request(OP_ADD, $urandom, grp_b);

        // capacity lowered under the held count: adds evict one and keep the count
        wait_idle();
        write_capacity(7'd64);
        for (int i = 0; i < 5; i++)
            send_request(OP_ADD, $urandom, (i % 2 == 0) ? grp_a : grp_b);
        wait_idle();
        write_capacity(7'd2);
        send_request(OP_ADD, $urandom, grp_a);
        send_request(OP_ADD, $urandom, grp_b);
        send_request(OP_DRAIN, $urandom, grp_a);
        send_request(OP_DRAIN, $urandom, grp_b);

        // capacity above the store depth saturates
        wait_idle();
        write_capacity(7'd127);
        send_request(OP_ADD, $urandom, grp_a);
        send_request(OP_DRAIN, $urandom, $urandom);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_capacity(phase_cap[p]);
            foreach (group_pool[g])
                group_pool[g] = $urandom;
            for (int n = 0; n < phase_len[p]; n++) begin
                if ($urandom_range(1, 100) <= add_pct[p])
                    send_request(OP_ADD, $urandom, pick_group());
                else
                    send_request(OP_DRAIN, $urandom, pick_group());
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
sv/ofkd_pkg.sv
sv/ofkd_store.sv
sv/overwrite_fifo_keyed_drain_unit.sv
sv/ofkd_checker.sv
sim/ofkd_checker.sv
sim/tb_overwrite_fifo_keyed_drain_unit.sv
